@@ hw/rtl/smbe_pkg.sv @@
// smbe_pkg: shared constants, phase codes and payload types of the spi byte engine
// no dependencies; imported by every module of the block
package smbe_pkg;

    localparam int WORD_BITS  = 8;
    localparam int PHASE_W    = 3;
    localparam int BITS_W     = 4;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    // per-bit phases, tail is the trailing gap after the last bit
    localparam logic [PHASE_W-1:0] PH_MOSI   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RISE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SAMPLE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FALL   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TAIL   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 2'd1;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 8'd4;
    localparam logic              INVERT_RST      = 1'b1;

    // request type codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    typedef struct packed {
        logic                 is_cmd;
        logic [WORD_BITS-1:0] tx_byte;
        logic                 frame_start;
        logic                 frame_end;
        logic                 miso;
    } t_smbe_op;

    typedef struct packed {
        logic                 cs_pin;
        logic                 sck_pin;
        logic                 mosi_pin;
        logic                 busy_res;
        logic                 rx_valid;
        logic [WORD_BITS-1:0] rx_byte;
        logic                 cmd_rejected;
    } t_smbe_res;

    typedef struct packed {
        logic [TICK_W-1:0] phase_ticks;
        logic              invert_outputs;
    } t_smbe_cfg;

endpackage

@@ hw/rtl/smbe_if.sv @@
// smbe_if: valid/ready channel interfaces for requests, results and config writes
// depends on smbe_pkg for widths
interface smbe_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [smbe_pkg::WORD_BITS-1:0] tx_byte;
    logic                           frame_start;
    logic                           frame_end;
    logic                           miso_level;

    modport source (output valid, req_type, tx_byte, frame_start, frame_end, miso_level,
                    input ready);
    modport sink   (input valid, req_type, tx_byte, frame_start, frame_end, miso_level,
                    output ready);
endinterface

interface smbe_res_if;
    logic                           valid;
    logic                           ready;
    logic                           cs_pin;
    logic                           sck_pin;
    logic                           mosi_pin;
    logic                           busy_res;
    logic                           rx_valid;
    logic [smbe_pkg::WORD_BITS-1:0] rx_byte;
    logic                           cmd_rejected;

    modport source (output valid, cs_pin, sck_pin, mosi_pin, busy_res, rx_valid, rx_byte,
                    cmd_rejected, input ready);
    modport sink   (input valid, cs_pin, sck_pin, mosi_pin, busy_res, rx_valid, rx_byte,
                    cmd_rejected, output ready);
endinterface

interface smbe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [smbe_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [smbe_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ hw/rtl/smbe_front.sv @@
// smbe_front: accepts request items and classifies them into engine ops
// depends on smbe_pkg and smbe_if
module smbe_front (
    smbe_req_if.sink            i_req,
    output logic                o_push,
    output smbe_pkg::t_smbe_op  o_op,
    input  logic                i_q_ready
);
    import smbe_pkg::*;

    // ticks carry only miso, commands only their byte and frame flags
    always_comb begin
        o_op.is_cmd      = (i_req.req_type == REQ_CMD);
        o_op.tx_byte     = o_op.is_cmd ? i_req.tx_byte : '0;
        o_op.frame_start = o_op.is_cmd & i_req.frame_start;
        o_op.frame_end   = o_op.is_cmd & i_req.frame_end;
        o_op.miso        = ~o_op.is_cmd & i_req.miso_level;
    end

    assign i_req.ready = i_q_ready;
    assign o_push      = i_req.valid & i_q_ready;

endmodule

@@ hw/rtl/smbe_queue.sv @@
// smbe_queue: two-entry op queue between front and back
// depends on smbe_pkg
module smbe_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  smbe_pkg::t_smbe_op i_op,
    output logic               o_ready,
    output logic               o_valid,
    output smbe_pkg::t_smbe_op o_op,
    input  logic               i_pop
);
    import smbe_pkg::*;

    t_smbe_op            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("op queue count out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("op queue popped while empty");

    a_push_notfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("op queue pushed while full");

endmodule

@@ hw/rtl/smbe_back.sv @@
// smbe_back: spi bit engine, one op a cycle unless the result stalls; registers the result item
// depends on smbe_pkg and smbe_if
module smbe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smbe_pkg::t_smbe_cfg i_cfg,
    input  logic                i_q_valid,
    input  smbe_pkg::t_smbe_op  i_op,
    output logic                o_pop,
    smbe_res_if.source          o_res
);
    import smbe_pkg::*;

    logic                 r_busy,  n_busy;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [TICK_W-1:0]    r_tick,  n_tick;
    logic [BITS_W-1:0]    r_bits,  n_bits;
    logic [WORD_BITS-1:0] r_tx,    n_tx;
    logic [WORD_BITS-1:0] r_rx,    n_rx;
    logic                 r_cs,    n_cs;
    logic                 r_sck,   n_sck;
    logic                 r_mosi,  n_mosi;
    logic                 r_endp,  n_endp;

    logic                 r_out_valid;
    t_smbe_res            r_out, n_out;

    logic [TICK_W-1:0]    limit;
    logic [TICK_W:0]      tc;

    assign o_pop = i_q_valid & (~r_out_valid | o_res.ready);

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bits  = r_bits;
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_cs    = r_cs;
        n_sck   = r_sck;
        n_mosi  = r_mosi;
        n_endp  = r_endp;
        n_out.rx_valid     = 1'b0;
        n_out.rx_byte      = '0;
        n_out.cmd_rejected = 1'b0;
        limit = (i_cfg.phase_ticks == '0) ? TICK_W'(1) : i_cfg.phase_ticks;
        tc    = {1'b0, r_tick} + (TICK_W+1)'(1);

        if (o_pop) begin
            if (i_op.is_cmd) begin
                if (r_busy) begin
                    n_out.cmd_rejected = 1'b1;
                end else begin
                    if (i_op.frame_start) begin
                        n_cs = 1'b1;
                    end
                    n_tx    = i_op.tx_byte;
                    n_rx    = '0;
                    n_bits  = BITS_W'(WORD_BITS);
                    n_phase = PH_MOSI;
                    n_tick  = '0;
                    n_endp  = i_op.frame_end;
                    n_busy  = 1'b1;
                end
            end else if (r_busy) begin
                if (tc < {1'b0, limit}) begin
                    n_tick = tc[TICK_W-1:0];
                end else begin
                    n_tick = '0;
                    case (r_phase)
                        PH_MOSI: begin
                            n_mosi  = r_tx[WORD_BITS-1];
                            n_phase = PH_RISE;
                        end
                        PH_RISE: begin
                            n_sck   = 1'b1;
                            n_phase = PH_SAMPLE;
                        end
                        PH_SAMPLE: begin
                            n_rx    = {r_rx[WORD_BITS-2:0], i_op.miso};
                            n_tx    = {r_tx[WORD_BITS-2:0], 1'b0};
                            n_phase = PH_FALL;
                        end
                        PH_FALL: begin
                            n_sck   = 1'b0;
                            n_bits  = r_bits - BITS_W'(1);
                            n_phase = (n_bits == '0) ? PH_TAIL : PH_MOSI;
                        end
                        default: begin
                            // trailing gap done, report the byte
                            n_out.rx_valid = 1'b1;
                            n_out.rx_byte  = r_rx;
                            if (r_endp) begin
                                n_cs = 1'b0;
                            end
                            n_endp  = 1'b0;
                            n_busy  = 1'b0;
                            n_phase = PH_MOSI;
                        end
                    endcase
                end
            end
        end

        n_out.cs_pin   = ~n_cs ^ i_cfg.invert_outputs;
        n_out.sck_pin  = n_sck ^ i_cfg.invert_outputs;
        n_out.mosi_pin = n_mosi ^ i_cfg.invert_outputs;
        n_out.busy_res = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_MOSI;
            r_tick      <= '0;
            r_bits      <= '0;
            r_tx        <= '0;
            r_rx        <= '0;
            r_cs        <= 1'b0;
            r_sck       <= 1'b0;
            r_mosi      <= 1'b0;
            r_endp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bits      <= n_bits;
            r_tx        <= n_tx;
            r_rx        <= n_rx;
            r_cs        <= n_cs;
            r_sck       <= n_sck;
            r_mosi      <= n_mosi;
            r_endp      <= n_endp;
            r_out_valid <= o_pop | (r_out_valid & ~o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.cs_pin       = r_out.cs_pin;
    assign o_res.sck_pin      = r_out.sck_pin;
    assign o_res.mosi_pin     = r_out.mosi_pin;
    assign o_res.busy_res     = r_out.busy_res;
    assign o_res.rx_valid     = r_out.rx_valid;
    assign o_res.rx_byte      = r_out.rx_byte;
    assign o_res.cmd_rejected = r_out.cmd_rejected;

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_phase == PH_MOSI && r_endp == 1'b0))
        else $error("idle engine holds a stale phase or frame end");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BITS_W'(WORD_BITS))
        else $error("bit counter above word size");

    a_rx_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rx_valid) |-> !r_out.busy_res && !r_out.cmd_rejected)
        else $error("received byte reported while still busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.is_cmd && r_busy) |=> (r_busy && $stable(r_tx)))
        else $error("rejected command disturbed the transfer");

endmodule

@@ hw/rtl/spi_master_byte_engine.sv @@
// spi_master_byte_engine: top level of the spi mode-0 byte engine
// depends on smbe_pkg, smbe_if, smbe_front, smbe_queue and smbe_back
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------------
//  i_req    | in  | valid/ready   | req_type, tx_byte, frame_start, frame_end, miso_level
//  o_res    | out | valid/ready   | cs/sck/mosi pins, busy_res, rx_valid, rx_byte, cmd_rejected
//  i_cfg    | in  | valid/ready   | reg_index (0 phase_ticks, 1 invert_outputs), wr_data
//
// one item per cycle sustained while o_res is not stalled: each item is applied to the
// engine state by the phase/tick update in the back engine
// an accepted item is written to a queue entry, then its result to the result register
// reset is synchronous and active low; no clearing pass, the engine is ready right away
// a stalled result holds in the result register while the two-entry queue absorbs items
module spi_master_byte_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smbe_req_if.sink   i_req,
    smbe_res_if.source o_res,
    smbe_cfg_if.sink   i_cfg
);
    import smbe_pkg::*;

    // configuration registers; the user must write them only while no item is in flight, the block does not enforce it
    t_smbe_cfg r_cfg;

    logic      push;
    t_smbe_op  push_op;
    logic      q_ready;
    logic      q_valid;
    t_smbe_op  q_op;
    logic      pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks    <= PHASE_TICKS_RST;
            r_cfg.invert_outputs <= INVERT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_PHASE_TICKS: r_cfg.phase_ticks    <= i_cfg.wr_data[TICK_W-1:0];
                CFG_INVERT:      r_cfg.invert_outputs <= i_cfg.wr_data[0];
                default: begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    // front: accept and classify request items
    smbe_front u_front (
        .i_req     (i_req),
        .o_push    (push),
        .o_op      (push_op),
        .i_q_ready (q_ready)
    );

    // short queue decoupling acceptance from the engine
    smbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (pop)
    );

    // back: phase sequencer, shifters and result register
    smbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
